>>> sv/rofc_pkg.sv
// Shared package of the open-file table: field widths, function and status
// codes, and the descriptor command struct. No dependencies.
package rofc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned FDS_PER_PROC_DEF  = 32;
  localparam int unsigned PROC_COUNT_DEF    = 8;
  localparam int unsigned COUNT_BITS_DEF    = 16;
  localparam int unsigned INFO_BITS_DEF     = 64;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned PROC_W   = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FD_W     = 5;
  localparam int unsigned INFO_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 17;

  typedef enum logic [FUNC_W-1:0] {
    FN_COUNT     = 3'd0,
    FN_OPEN      = 3'd1,
    FN_CLOSE     = 3'd2,
    FN_INFO_FD   = 3'd3,
    FN_INFO_ADDR = 3'd4,
    FN_UPDATE    = 3'd5
  } rofc_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_FD     = 3'd3,
    ST_BAD_FD    = 3'd4,
    ST_BAD_ADDR  = 3'd5
  } rofc_status_e;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;

  typedef struct packed {
    logic we;
    logic set;
    logic wr;
  } rofc_desc_cmd_t;

endpackage

>>> sv/rofc_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on rofc_pkg.
interface rofc_req_if;
  import rofc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PROC_W-1:0] proc;
  logic [ADDR_W-1:0] naddr;
  logic [MODE_W-1:0] mode;
  logic [FD_W-1:0]   fd;
  logic [INFO_W-1:0] info;
  modport source(output valid, func, proc, naddr, mode, fd, info, input ready);
  modport sink(input valid, func, proc, naddr, mode, fd, info, output ready);
endinterface

interface rofc_rsp_if;
  import rofc_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [FD_W-1:0]     fd_out;
  logic [INFO_W-1:0]   info_out;
  modport source(output valid, status, count, fd_out, info_out, input ready);
  modport sink(input valid, status, count, fd_out, info_out, output ready);
endinterface

>>> sv/refcounted_open_file_table_top.sv
// Count query, open, info by address and update run the one-entry-per-cycle key scan
// from acceptance, then execute and present the result.
// Close and info by descriptor run a descriptor read, an entry read and an execute step that writes back for close.
// Rejected items skip to the result. One item is in work at a time; the next
// can be accepted while the result is presented. Reset clears all entry and descriptor
// valid bits at once. Depends on rofc_pkg, rofc_if and rofc_desc_table.
module refcounted_open_file_table_top #(
  parameter int unsigned TABLE_ENTRIES = rofc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FDS_PER_PROC  = rofc_pkg::FDS_PER_PROC_DEF,
  parameter int unsigned PROC_COUNT    = rofc_pkg::PROC_COUNT_DEF,
  parameter int unsigned COUNT_BITS    = rofc_pkg::COUNT_BITS_DEF,
  parameter int unsigned INFO_BITS     = rofc_pkg::INFO_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rofc_req_if.sink   in_i,
  rofc_rsp_if.source out_o
);
  import rofc_pkg::*;

  localparam int unsigned Eiw = $clog2(TABLE_ENTRIES);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef struct packed {
    logic [ADDR_W-1:0]     key;
    logic [COUNT_BITS-1:0] rc;
    logic [COUNT_BITS-1:0] wc;
    logic [INFO_BITS-1:0]  info;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_END, S_DESC_RD, S_ENT_RD, S_ENT_WAIT, S_EXEC, S_RESP
  } state_e;

  state_e state_q;

  logic [FUNC_W-1:0]    func_q;
  logic [PROC_W-1:0]    proc_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [MODE_W-1:0]    mode_q;
  logic [FD_W-1:0]      fd_q;
  logic [INFO_BITS-1:0] info_q;

  logic [Eiw-1:0] scan_q, cmp_idx_q, hit_idx_q, free_idx_q;
  logic           cmp_q, hit_q, free_q;
  ent_t           hit_word_q;

  ent_t           mem_q [TABLE_ENTRIES];
  ent_t           mem_rd_q;
  logic           rd_en;
  logic [Eiw-1:0] rd_addr;
  logic           mem_we;
  logic [Eiw-1:0] mem_wa;
  ent_t           mem_wd;

  logic [TABLE_ENTRIES-1:0] ev_q;
  logic                     ev_set, ev_clr;
  logic [Eiw-1:0]           ev_idx;

  rofc_status_e      res_status_q, ex_status;
  logic [COUNT_W-1:0] res_count_q, ex_count;
  logic [FD_W-1:0]    res_fd_q, ex_fd;
  logic [INFO_W-1:0]  res_info_q, ex_info;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [FD_W-1:0]     out_fd_q;
  logic [INFO_W-1:0]   out_info_q;

  rofc_desc_cmd_t dcmd;
  logic           d_fd_valid, d_free_found, d_wr;
  logic [FD_W-1:0] d_free_fd;
  logic [Eiw-1:0] d_slot, d_wslot;

  rofc_desc_table #(
    .FDS_PER_PROC(FDS_PER_PROC),
    .PROC_COUNT  (PROC_COUNT),
    .EIW         (Eiw)
  ) u_desc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc_q),
    .fd_i        (fd_q),
    .wr_fd_i     ((func_q == FN_OPEN) ? d_free_fd : fd_q),
    .fd_valid_o  (d_fd_valid),
    .free_found_o(d_free_found),
    .free_fd_o   (d_free_fd),
    .cmd_i       (dcmd),
    .slot_i      (d_wslot),
    .slot_o      (d_slot),
    .wr_o        (d_wr)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.count     = out_count_q;
  assign out_o.fd_out    = out_fd_q;
  assign out_o.info_out  = out_info_q;

  assign rd_en   = (state_q == S_SCAN) || (state_q == S_ENT_RD);
  assign rd_addr = (state_q == S_SCAN) ? scan_q : d_slot;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else if (ev_set) begin
      ev_q[ev_idx] <= 1'b1;
    end else if (ev_clr) begin
      ev_q[ev_idx] <= 1'b0;
    end
  end

  // Work done when the lookup or the entry read has finished.
  always_comb begin
    logic                  wr;
    logic [Eiw-1:0]        e;
    logic [COUNT_BITS-1:0] rc, wc;
    logic [COUNT_BITS:0]   sum;
    logic [31:0]           cnt32;
    ent_t                  cur;
    wr        = (mode_q != MODE_READ);
    e         = hit_q ? hit_idx_q : free_idx_q;
    cur       = hit_word_q;
    rc        = '0;
    wc        = '0;
    sum       = '0;
    cnt32     = '0;
    ex_status = ST_OK;
    ex_count  = '0;
    ex_fd     = '0;
    ex_info   = '0;
    mem_we    = 1'b0;
    mem_wa    = e;
    mem_wd    = cur;
    ev_set    = 1'b0;
    ev_clr    = 1'b0;
    ev_idx    = e;
    dcmd      = '0;
    d_wslot   = e;
    if (state_q == S_EXEC) begin
      case (func_q)
        FN_COUNT: begin
          if (!hit_q) begin
            ex_status = ST_NOT_FOUND;
          end else begin
            sum = {1'b0, cur.rc} + {1'b0, cur.wc};
            if (mode_q == MODE_READ) begin
              cnt32 = 32'(cur.rc);
            end else if (mode_q == MODE_WRITE) begin
              cnt32 = 32'(cur.wc);
            end else begin
              cnt32 = 32'(sum);
            end
            ex_count = cnt32[COUNT_W-1:0];
          end
        end
        FN_INFO_ADDR: begin
          if (!hit_q) begin
            ex_status = ST_NOT_FOUND;
          end else begin
            ex_info = INFO_W'(cur.info);
          end
        end
        FN_UPDATE: begin
          if (!hit_q) begin
            ex_status = ST_NOT_FOUND;
          end else begin
            mem_we      = 1'b1;
            mem_wd.info = info_q;
          end
        end
        FN_OPEN: begin
          if (!hit_q && !free_q) begin
            ex_status = ST_FULL;
          end else begin
            rc = hit_q ? cur.rc : '0;
            wc = hit_q ? cur.wc : '0;
            mem_wd.key  = addr_q;
            mem_wd.info = info_q;
            if (!d_free_found) begin
              ex_status = ST_NO_FD;
              mem_wd.rc = rc;
              mem_wd.wc = wc;
              mem_we    = hit_q;
            end else begin
              mem_wd.rc = (!wr && rc != CountMax) ? rc + 1'b1 : rc;
              mem_wd.wc = (wr && wc != CountMax) ? wc + 1'b1 : wc;
              mem_we    = 1'b1;
              ev_set    = !hit_q;
              dcmd      = '{we: 1'b1, set: 1'b1, wr: wr};
              ex_fd     = d_free_fd;
            end
          end
        end
        FN_CLOSE: begin
          ev_idx = d_slot;
          mem_wa = d_slot;
          mem_wd = mem_rd_q;
          dcmd   = '{we: 1'b1, set: 1'b0, wr: 1'b0};
          if (ev_q[d_slot]) begin
            rc = mem_rd_q.rc;
            wc = mem_rd_q.wc;
            if (d_wr) begin
              wc = (wc != '0) ? wc - 1'b1 : wc;
            end else begin
              rc = (rc != '0) ? rc - 1'b1 : rc;
            end
            mem_wd.rc = rc;
            mem_wd.wc = wc;
            mem_we    = 1'b1;
            ev_clr    = (rc == '0) && (wc == '0);
          end
        end
        FN_INFO_FD: begin
          if (!ev_q[d_slot]) begin
            ex_status = ST_NOT_FOUND;
          end else begin
            ex_info = INFO_W'(mem_rd_q.info);
          end
        end
        default: begin
          ex_status = ST_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      cmp_q        <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      scan_q       <= '0;
      func_q       <= '0;
      res_status_q <= ST_OK;
    end else begin
      if (out_valid_q && out_o.ready && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      cmp_q     <= (state_q == S_SCAN);
      cmp_idx_q <= scan_q;
      if (cmp_q) begin
        if (ev_q[cmp_idx_q] && mem_rd_q.key == addr_q && !hit_q) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= cmp_idx_q;
          hit_word_q <= mem_rd_q;
        end
        if (!ev_q[cmp_idx_q]) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            func_q      <= in_i.func;
            proc_q      <= in_i.proc;
            addr_q      <= in_i.naddr;
            mode_q      <= in_i.mode;
            fd_q        <= in_i.fd;
            info_q      <= in_i.info[INFO_BITS-1:0];
            hit_q       <= 1'b0;
            free_q      <= 1'b0;
            scan_q      <= '0;
            res_count_q <= '0;
            res_fd_q    <= '0;
            res_info_q  <= '0;
            case (in_i.func)
              FN_COUNT, FN_INFO_ADDR, FN_UPDATE, FN_OPEN: begin
                if (in_i.naddr == '0) begin
                  res_status_q <= ST_BAD_ADDR;
                  state_q      <= S_RESP;
                end else if (in_i.func == FN_OPEN && int'(in_i.proc) >= PROC_COUNT) begin
                  res_status_q <= ST_NO_FD;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              FN_CLOSE, FN_INFO_FD: begin
                state_q <= S_DESC_RD;
              end
              default: begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == Eiw'(TABLE_ENTRIES - 1)) begin
            state_q <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          state_q <= S_EXEC;
        end
        S_DESC_RD: begin
          if (!d_fd_valid) begin
            res_status_q <= ST_BAD_FD;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_ENT_RD;
          end
        end
        S_ENT_RD: begin
          state_q <= S_ENT_WAIT;
        end
        S_ENT_WAIT: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_status_q <= ex_status;
          res_count_q  <= ex_count;
          res_fd_q     <= ex_fd;
          res_info_q   <= ex_info;
          state_q      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_count_q  <= res_count_q;
            out_fd_q     <= res_fd_q;
            out_info_q   <= res_info_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("entry memory written during key scan");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !$rose(out_o.valid))
    else $error("result appeared one cycle after acceptance");

  a_nofd_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_status_q == ST_NO_FD) |-> (func_q == FN_OPEN))
    else $error("no-free-descriptor status from a function other than open");

  a_alloc_free_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_set |-> !ev_q[ev_idx])
    else $error("allocation of an entry that is in use");

endmodule

>>> sv/rofc_desc_table.sv
// Per-process descriptor table: valid bits in flip-flops, slot and mode in a
// synchronous memory, and a lowest-free-descriptor finder. Depends on rofc_pkg.
module rofc_desc_table #(
  parameter int unsigned FDS_PER_PROC = rofc_pkg::FDS_PER_PROC_DEF,
  parameter int unsigned PROC_COUNT   = rofc_pkg::PROC_COUNT_DEF,
  parameter int unsigned EIW          = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rofc_pkg::PROC_W-1:0]  proc_i,
  input  logic [rofc_pkg::FD_W-1:0]    fd_i,
  input  logic [rofc_pkg::FD_W-1:0]    wr_fd_i,
  output logic                         fd_valid_o,
  output logic                         free_found_o,
  output logic [rofc_pkg::FD_W-1:0]    free_fd_o,
  input  rofc_pkg::rofc_desc_cmd_t     cmd_i,
  input  logic [EIW-1:0]               slot_i,
  output logic [EIW-1:0]               slot_o,
  output logic                         wr_o
);
  import rofc_pkg::*;

  localparam int unsigned DescTotal = PROC_COUNT * FDS_PER_PROC;
  localparam int unsigned Diw       = (DescTotal > 1) ? $clog2(DescTotal) : 1;
  localparam int unsigned Usable    = (FDS_PER_PROC < 32) ? FDS_PER_PROC : 32;

  logic [DescTotal-1:0] valid_q;
  logic [EIW:0]         mem_q [DescTotal];
  logic [EIW:0]         rd_q;
  logic [Diw-1:0]       rd_idx, wr_idx;
  logic                 proc_ok, rd_ok;
  int unsigned          base;

  assign base    = int'(proc_i) * FDS_PER_PROC;
  assign proc_ok = int'(proc_i) < PROC_COUNT;
  assign rd_ok   = proc_ok && (int'(fd_i) < Usable);
  assign rd_idx  = Diw'(base + int'(fd_i));
  assign wr_idx  = Diw'(base + int'(wr_fd_i));

  assign fd_valid_o = rd_ok && valid_q[rd_idx];

  always_comb begin
    free_found_o = 1'b0;
    free_fd_o    = '0;
    for (int d = 0; d < Usable; d++) begin
      if (proc_ok && !free_found_o && !valid_q[Diw'(base + d)]) begin
        free_found_o = 1'b1;
        free_fd_o    = FD_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.we) begin
      valid_q[wr_idx] <= cmd_i.set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we && cmd_i.set) begin
      mem_q[wr_idx] <= {cmd_i.wr, slot_i};
    end
    rd_q <= mem_q[rd_idx];
  end

  assign slot_o = rd_q[EIW-1:0];
  assign wr_o   = rd_q[EIW];

endmodule

>>> test/refcounted_open_file_table_top_test.sv
// Self-checking testbench of the open-file table: a queue-fed driver, a monitor
// and a predictor of the table and descriptor state that checks every response item.
// Depends on rofc_pkg, rofc_if and the refcounted_open_file_table_top RTL.
`timescale 1ns / 100ps

module refcounted_open_file_table_top_test;
  import rofc_pkg::*;

  localparam int ENTRIES = 128;
  localparam int PROCS = 8;
  localparam int FDS = 32;
  localparam int CNT_MAX = 65535;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PROC_W-1:0] proc;
    logic [ADDR_W-1:0] naddr;
    logic [MODE_W-1:0] mode;
    logic [FD_W-1:0]   fd;
    logic [INFO_W-1:0] info;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [FD_W-1:0]     fd_out;
    logic [INFO_W-1:0]   info_out;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rofc_req_if req_bus();
  rofc_rsp_if rsp_bus();

  refcounted_open_file_table_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_bus.sink), .out_o(rsp_bus.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] key_tab[ENTRIES];
  int          rd_cnt[ENTRIES];
  int          wr_cnt[ENTRIES];
  logic [63:0] info_tab[ENTRIES];
  bit          fd_used[PROCS][FDS];
  int          fd_entry[PROCS][FDS];
  bit          fd_wr[PROCS][FDS];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int accepted = 0;
  int sent = 0;
  int total_reqs = 0;
  logic [31:0] key_pool[16];

  task automatic report(input string what);
    $display("%0t: error: %s", $realtime, what);
    errors++;
  endtask

  function automatic int lookup(input logic [31:0] key, output int free_at);
    int hit;
    hit = -1;
    free_at = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_tab[i] == 0) free_at = i;
      else if (key_tab[i] == key && hit < 0) hit = i;
    end
    return hit;
  endfunction

  function automatic answer_t predict_table(input request_t r);
    answer_t a;
    int e, fr, d, old_r, old_w;
    bit wr, fresh;
    a = '0;
    wr = (r.mode != MODE_READ);
    case (r.func)
      FN_COUNT: begin
        if (r.naddr == 0) a.status = ST_BAD_ADDR;
        else begin
          e = lookup(r.naddr, fr);
          if (e < 0) a.status = ST_NOT_FOUND;
          else if (r.mode == MODE_READ) a.count = COUNT_W'(rd_cnt[e]);
          else if (r.mode == MODE_WRITE) a.count = COUNT_W'(wr_cnt[e]);
          else a.count = COUNT_W'(rd_cnt[e] + wr_cnt[e]);
        end
      end
      FN_OPEN: begin
        if (r.naddr == 0) a.status = ST_BAD_ADDR;
        else begin
          fresh = 0;
          e = lookup(r.naddr, fr);
          if (e < 0 && fr < 0) a.status = ST_FULL;
          else begin
            if (e < 0) begin
              e = fr;
              fresh = 1;
              key_tab[e] = r.naddr;
              rd_cnt[e] = 0;
              wr_cnt[e] = 0;
            end
            old_r = rd_cnt[e];
            old_w = wr_cnt[e];
            if (wr) begin
              if (wr_cnt[e] < CNT_MAX) wr_cnt[e]++;
            end else if (rd_cnt[e] < CNT_MAX) begin
              rd_cnt[e]++;
            end
            info_tab[e] = r.info;
            d = 0;
            while (d < FDS && fd_used[r.proc][d]) d++;
            if (d >= FDS) begin
              rd_cnt[e] = old_r;
              wr_cnt[e] = old_w;
              if (fresh) key_tab[e] = 0;
              a.status = ST_NO_FD;
            end else begin
              fd_used[r.proc][d] = 1;
              fd_entry[r.proc][d] = e;
              fd_wr[r.proc][d] = wr;
              a.fd_out = FD_W'(d);
            end
          end
        end
      end
      FN_CLOSE, FN_INFO_FD: begin
        if (!fd_used[r.proc][r.fd]) a.status = ST_BAD_FD;
        else begin
          e = fd_entry[r.proc][r.fd];
          if (r.func == FN_CLOSE) begin
            if (key_tab[e] != 0) begin
              if (fd_wr[r.proc][r.fd]) begin
                if (wr_cnt[e] > 0) wr_cnt[e]--;
              end else if (rd_cnt[e] > 0) begin
                rd_cnt[e]--;
              end
              if (rd_cnt[e] == 0 && wr_cnt[e] == 0) key_tab[e] = 0;
            end
            fd_used[r.proc][r.fd] = 0;
            fd_wr[r.proc][r.fd] = 0;
            fd_entry[r.proc][r.fd] = 0;
          end else if (key_tab[e] == 0) a.status = ST_NOT_FOUND;
          else a.info_out = info_tab[e];
        end
      end
      FN_INFO_ADDR, FN_UPDATE: begin
        if (r.naddr == 0) a.status = ST_BAD_ADDR;
        else begin
          e = lookup(r.naddr, fr);
          if (e < 0) a.status = ST_NOT_FOUND;
          else if (r.func == FN_INFO_ADDR) a.info_out = info_tab[e];
          else info_tab[e] = r.info;
        end
      end
      default: a.status = ST_NOT_FOUND;
    endcase
    return a;
  endfunction

  function automatic request_t make_req(input int unsigned f, input int unsigned p,
                                        input logic [31:0] k, input int unsigned m,
                                        input int unsigned d, input logic [63:0] w);
    request_t r;
    r.func = FUNC_W'(f);
    r.proc = PROC_W'(p);
    r.naddr = k;
    r.mode = MODE_W'(m);
    r.fd = FD_W'(d);
    r.info = w;
    return r;
  endfunction

  function automatic logic [63:0] rand_info();
    return {$urandom, $urandom};
  endfunction

  // Driver: presents queued items after a random gap, changing inputs on the falling edge.
  int drive_gap = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      {req_bus.func, req_bus.proc, req_bus.naddr, req_bus.mode, req_bus.fd,
       req_bus.info} <= '0;
    end else if (req_bus.valid && accepted == sent) begin
      req_bus.valid <= 1'b0;
      drive_gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) drive_gap = 0;
    end else if (!req_bus.valid && pending_reqs.size() > 0) begin
      if (drive_gap > 0) drive_gap--;
      else begin
        request_t r;
        r = pending_reqs.pop_front();
        req_bus.func <= r.func;
        req_bus.proc <= r.proc;
        req_bus.naddr <= r.naddr;
        req_bus.mode <= r.mode;
        req_bus.fd <= r.fd;
        req_bus.info <= r.info;
        req_bus.valid <= 1'b1;
        sent++;
      end
    end
  end

  // The ready of the response side is redrawn for each item.
  int sink_gap = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_bus.ready && rsp_bus.valid) begin
      sink_gap = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) sink_gap = 0;
      if (sink_gap > 0) rsp_bus.ready <= 1'b0;
    end else if (!rsp_bus.ready) begin
      if (sink_gap > 0) sink_gap--;
      else rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      request_t r;
      r = '{func: req_bus.func, proc: req_bus.proc, naddr: req_bus.naddr,
            mode: req_bus.mode, fd: req_bus.fd, info: req_bus.info};
      expected_answers.push_back(predict_table(r));
      accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      answer_t exp_a;
      if (expected_answers.size() == 0) report("response item with none expected");
      else begin
        exp_a = expected_answers.pop_front();
        if (rsp_bus.status !== exp_a.status)
          report($sformatf("status %0d, expected %0d", rsp_bus.status, exp_a.status));
        if (rsp_bus.count !== exp_a.count)
          report($sformatf("count %0d, expected %0d", rsp_bus.count, exp_a.count));
        if (rsp_bus.fd_out !== exp_a.fd_out)
          report($sformatf("fd_out %0d, expected %0d", rsp_bus.fd_out, exp_a.fd_out));
        if (rsp_bus.info_out !== exp_a.info_out)
          report($sformatf("info_out %h, expected %h", rsp_bus.info_out, exp_a.info_out));
      end
    end
  end

  task automatic push(input request_t r);
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  initial begin
    int pick, p;
    logic [31:0] k;
    for (int i = 0; i < ENTRIES; i++) begin
      key_tab[i] = 0;
      rd_cnt[i] = 0;
      wr_cnt[i] = 0;
      info_tab[i] = 0;
    end
    for (int i = 0; i < PROCS; i++)
      for (int j = 0; j < FDS; j++) begin
        fd_used[i][j] = 0;
        fd_entry[i][j] = 0;
        fd_wr[i][j] = 0;
      end
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom | 32'h1;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h1;

    // Directed items: zero address, unknown functions, empty descriptors, every mode.
    push(make_req(FN_OPEN, 0, 0, MODE_READ, 0, '1));
    push(make_req(FN_COUNT, 0, 0, 2'd2, 0, 0));
    push(make_req(FN_INFO_ADDR, 0, 0, 0, 0, 0));
    push(make_req(FN_UPDATE, 0, 0, 0, 0, 0));
    push(make_req(3'd6, 7, '1, 2'd3, '1, '1));
    push(make_req(3'd7, 0, 0, 0, 0, 0));
    push(make_req(FN_CLOSE, 7, 0, 0, 31, 0));
    push(make_req(FN_INFO_FD, 0, 0, 0, 0, 0));
    push(make_req(FN_COUNT, 0, 32'hFFFF_FFFF, 0, 0, 0));
    push(make_req(FN_OPEN, 7, 32'hFFFF_FFFF, MODE_WRITE, 0, '1));
    push(make_req(FN_OPEN, 7, 32'hFFFF_FFFF, 2'd3, 0, 64'h0));
    push(make_req(FN_OPEN, 0, 32'h1, MODE_READ, 0, 64'h5555_AAAA_5555_AAAA));
    push(make_req(FN_COUNT, 0, 32'hFFFF_FFFF, MODE_READ, 0, 0));
    push(make_req(FN_COUNT, 0, 32'hFFFF_FFFF, MODE_WRITE, 0, 0));
    push(make_req(FN_COUNT, 0, 32'hFFFF_FFFF, 2'd3, 0, 0));
    push(make_req(FN_INFO_FD, 7, 0, 0, 1, 0));
    push(make_req(FN_UPDATE, 0, 32'h1, 0, 0, '1));
    push(make_req(FN_INFO_ADDR, 0, 32'h1, 0, 0, 0));
    push(make_req(FN_CLOSE, 7, 0, 0, 0, 0));
    push(make_req(FN_CLOSE, 7, 0, 0, 0, 0));
    push(make_req(FN_CLOSE, 7, 0, 0, 1, 0));
    push(make_req(FN_INFO_ADDR, 0, 32'hFFFF_FFFF, 0, 0, 0));
    // Exhaust the descriptors of process 3 to reach the no-free-descriptor case.
    for (int i = 0; i < 33; i++)
      push(make_req(FN_OPEN, 3, key_pool[i % 4], i % 2, 0, rand_info()));
    for (int i = 0; i < 32; i++) push(make_req(FN_CLOSE, 3, 0, 0, i, 0));

    // Mostly opens, queries and closes on a small key pool, plus bursts of
    // fresh keys that fill the table, bursts of closes and random items.
    while (total_reqs < 1600) begin
      p = $urandom_range(0, 7);
      k = key_pool[$urandom_range(0, 15)];
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        for (int i = 0; i < 40; i++)
          push(make_req(FN_OPEN, i % 8, $urandom | 32'h100, $urandom_range(0, 3), 0,
                        rand_info()));
      end else if (pick < 6) begin
        for (int i = 0; i < 40; i++)
          push(make_req(FN_CLOSE, i % 8, 0, 0, $urandom_range(0, 31), 0));
      end else if (pick < 35) begin
        push(make_req(FN_OPEN, p, k, $urandom_range(0, 3), $urandom, rand_info()));
      end else if (pick < 60) begin
        push(make_req(FN_CLOSE, p, $urandom, 0, $urandom_range(0, 31), 0));
      end else if (pick < 68) begin
        push(make_req(FN_INFO_FD, p, 0, 0, $urandom_range(0, 31), 0));
      end else if (pick < 78) begin
        push(make_req(FN_COUNT, p, k, $urandom_range(0, 3), 0, 0));
      end else if (pick < 86) begin
        push(make_req(FN_INFO_ADDR, p, k, 0, 0, rand_info()));
      end else if (pick < 94) begin
        push(make_req(FN_UPDATE, p, k, 0, 0, rand_info()));
      end else begin
        push(make_req($urandom_range(0, 7), p, ($urandom_range(0, 3) == 0) ? 0 : $urandom,
                      $urandom_range(0, 3), $urandom, rand_info()));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (accepted == total_reqs && pending_reqs.size() == 0);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
